### hw/rtl/uartrx_pkg.sv
// Shared types and constants for the UART receiver with receive FIFO.
// Used by every module of the block except uartrx_queue; depends on nothing else.
package uartrx_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COMPARE = 2'd1;

  localparam logic [7:0] PERIOD_TOP_RST     = 8'd207;
  localparam logic [7:0] SAMPLE_COMPARE_RST = 8'd103;

  // Bit phase loaded when a frame starts; counts down once per sample.
  localparam logic [3:0] START_PHASE = 4'd10;

  // Receive FIFO depth default and internal queue sizes.
  localparam int unsigned FIFO_DEPTH_DEF = 128;
  localparam int unsigned CMD_DEPTH      = 2;
  localparam int unsigned RES_DEPTH      = 4;
  localparam int unsigned RES_CNT_W      = $clog2(RES_DEPTH + 1);

  // Receive event codes.
  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_STORED      = 3'd1,
    EV_DROPPED     = 3'd2,
    EV_FRAMING     = 3'd3,
    EV_FALSE_START = 3'd4
  } rx_event_e;

  // One input item: one prescaled tick.
  typedef struct packed {
    logic rxd;
    logic read_request;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_data;
    logic [2:0] rx_event;
    logic       busy_res;
  } out_item_t;

  // Command from the line receiver to the FIFO side.
  typedef struct packed {
    logic       read_request;
    logic       store;
    logic [7:0] data;
    rx_event_e  rx_event;
    logic       busy;
  } cmd_t;

endpackage

### hw/rtl/uartrx_queue.sv
// Small first-in first-out queue built from registers.
// Generic; used for the command queue and the result queue of the receiver.
module uartrx_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/uartrx_front.sv
// Line receiver: bit timing, start/stop checks and data shifting.
// Holds the configuration registers; uses uartrx_pkg.
module uartrx_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              accept_i,
  input  uartrx_pkg::in_item_t              item_i,
  output uartrx_pkg::cmd_t                  cmd_o
);

  import uartrx_pkg::*;

  logic [7:0] period_top_q, sample_compare_q;
  logic       receiving_q, receiving_d;
  logic       prev_line_q;
  logic [7:0] tick_q, tick_d, tick_next;
  logic [3:0] phase_q, phase_d, phase_dec;
  logic [7:0] shift_q, shift_d;
  cmd_t       cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_top_q     <= PERIOD_TOP_RST;
      sample_compare_q <= SAMPLE_COMPARE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD_TOP:     period_top_q     <= cfg_wdata_i;
        REG_SAMPLE_COMPARE: sample_compare_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign tick_next = (tick_q == period_top_q) ? '0 : tick_q + 1'b1;
  assign phase_dec = phase_q - 1'b1;

  // Frame sequencing for one tick.
  always_comb begin
    receiving_d      = receiving_q;
    tick_d           = tick_q;
    phase_d          = phase_q;
    shift_d          = shift_q;
    cmd              = '0;
    cmd.read_request = item_i.read_request;
    cmd.rx_event     = EV_NONE;
    cmd.data         = shift_q;
    if (!receiving_q) begin
      if (prev_line_q && !item_i.rxd) begin
        receiving_d = 1'b1;
        tick_d      = '0;
        phase_d     = START_PHASE;
      end
    end else begin
      tick_d = tick_next;
      if (tick_next == sample_compare_q) begin
        phase_d = phase_dec;
        if (phase_dec == START_PHASE - 4'd1) begin
          if (item_i.rxd) begin
            receiving_d  = 1'b0;
            cmd.rx_event = EV_FALSE_START;
          end
        end else if (phase_dec == 4'd0) begin
          receiving_d = 1'b0;
          if (!item_i.rxd) begin
            cmd.rx_event = EV_FRAMING;
          end else begin
            cmd.store = 1'b1;
          end
        end else begin
          shift_d = {item_i.rxd, shift_q[7:1]};
        end
      end
    end
    cmd.busy = receiving_d;
  end

  assign cmd_o = cmd;

  // Receiver state, advanced on each accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      prev_line_q <= 1'b1;
      tick_q      <= '0;
      phase_q     <= '0;
      shift_q     <= '0;
    end else if (accept_i) begin
      receiving_q <= receiving_d;
      prev_line_q <= item_i.rxd;
      tick_q      <= tick_d;
      phase_q     <= phase_d;
      shift_q     <= shift_d;
    end
  end

endmodule

### hw/rtl/uartrx_back.sv
// Receive FIFO side: ring buffer memory, read and store of each command.
// Uses uartrx_pkg; feeds the result queue of the top level.
module uartrx_back #(
  parameter int unsigned FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  uartrx_pkg::cmd_t                 cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  input  logic [uartrx_pkg::RES_CNT_W-1:0] res_count_i,
  output logic                             res_push_o,
  output uartrx_pkg::out_item_t            res_o
);

  import uartrx_pkg::*;

  localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

  typedef struct packed {
    logic       read_valid;
    logic [2:0] rx_event;
    logic       busy;
  } meta_t;

  logic [7:0]       fifo_mem [FIFO_DEPTH];
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d, rd_nxt;
  logic             rd_ok, wr_ok, issue;
  logic [RES_CNT_W:0] occupancy;
  logic [7:0]       rdata_q;
  logic             s1_valid_q;
  meta_t            s1_meta_q, meta;

  // Issue only while the result queue has room for everything in flight.
  assign occupancy = {1'b0, res_count_i} + {{RES_CNT_W{1'b0}}, s1_valid_q};
  assign issue     = cmd_valid_i && (occupancy < (RES_CNT_W + 1)'(RES_DEPTH));
  assign cmd_pop_o = issue;

  // Read comes before the store of the same tick.
  always_comb begin
    rd_nxt   = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
    rd_ok    = cmd_i.read_request && (rd_nxt != wr_idx_q);
    rd_idx_d = rd_ok ? rd_nxt : rd_idx_q;
    wr_ok    = cmd_i.store && (wr_idx_q != rd_idx_d);
    wr_idx_d = wr_ok ? ((wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1) : wr_idx_q;
    meta.read_valid = rd_ok;
    meta.busy       = cmd_i.busy;
    if (cmd_i.store) begin
      meta.rx_event = wr_ok ? EV_STORED : EV_DROPPED;
    end else begin
      meta.rx_event = cmd_i.rx_event;
    end
  end

  // Ring indices and the output stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= IDX_W'(1);
      rd_idx_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      if (issue) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
      end
    end
  end

  // Buffer memory: one write and one registered read per cycle.
  // The read slot never equals the write slot of the same command.
  always_ff @(posedge clk_i) begin
    if (issue && wr_ok) begin
      fifo_mem[wr_idx_q] <= cmd_i.data;
    end
    if (issue && rd_ok) begin
      rdata_q <= fifo_mem[rd_nxt];
    end
    if (issue) begin
      s1_meta_q <= meta;
    end
  end

  // Result assembly from the output stage.
  assign res_push_o        = s1_valid_q;
  assign res_o.read_valid  = s1_meta_q.read_valid;
  assign res_o.read_data   = s1_meta_q.read_valid ? rdata_q : '0;
  assign res_o.rx_event    = s1_meta_q.rx_event;
  assign res_o.busy_res    = s1_meta_q.busy;

endmodule

### hw/rtl/uart_receiver_with_fifo_unit.sv
// UART receiver (8 data bits, no parity, one stop bit) with receive FIFO.
// Top level; uses uartrx_pkg, uartrx_front, uartrx_queue and uartrx_back.
//
// Each transfer on the input side is one prescaled tick: the receive line level and a
// read request. Exactly one result follows each tick, in order, with the popped byte (if
// any), the receive event and the busy flag. One tick is accepted every clock cycle while full
// is low; each result passes the command queue, the registered read of the FIFO memory and the
// result queue on its way to the output. full stays low as long as results are popped.
// Configuration writes take effect on the next tick and are meant for idle periods.
// The FIFO memory is not cleared at reset and needs no start-up sweep.
module uart_receiver_with_fifo_unit #(
  parameter int unsigned FIFO_DEPTH = uartrx_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  uartrx_pkg::in_item_t              in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output uartrx_pkg::out_item_t             out_item_o
);

  import uartrx_pkg::*;

  logic                 accept;
  cmd_t                 front_cmd, back_cmd;
  logic                 cmd_empty, cmd_pop;
  logic [RES_CNT_W-1:0] res_count;
  logic                 res_push;
  out_item_t            back_res;

  assign accept = push && !full;

  // Line receiver.
  uartrx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cmd_o       (front_cmd)
  );

  // Command queue between the receiver and the FIFO side.
  uartrx_queue #(
    .DEPTH (CMD_DEPTH),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // Receive FIFO.
  uartrx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Result queue towards the consumer.
  uartrx_queue #(
    .DEPTH (RES_DEPTH),
    .WIDTH ($bits(out_item_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty),
    .count_o (res_count)
  );

endmodule

### hw/rtl/uartrx_checker.sv
// Port-level assertions for the UART receiver with receive FIFO.
// Bound to uart_receiver_with_fifo_unit; uses uartrx_pkg.
module uartrx_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input uartrx_pkg::out_item_t out_item_o
);

  import uartrx_pkg::*;

  // A result without a popped byte carries zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.read_valid) |-> (out_item_o.read_data == 8'd0))
    else $error("read_data not zero without read_valid");

  // Event codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.rx_event == EV_NONE || out_item_o.rx_event == EV_STORED ||
                out_item_o.rx_event == EV_DROPPED || out_item_o.rx_event == EV_FRAMING ||
                out_item_o.rx_event == EV_FALSE_START))
    else $error("undefined receive event");

  // Any end-of-frame event leaves the receiver idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.rx_event != EV_NONE) |-> !out_item_o.busy_res)
    else $error("receiver busy after end-of-frame event");

  // A waiting result is held until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before transfer");

endmodule

bind uart_receiver_with_fifo_unit uartrx_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
